### sv/fcq_pkg.sv
// Shared types, constants and codes for the two-class oldest-first queue.
package fcq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int SEQ_BITS    = 6;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int FIELD_TAG_BITS = 16;

  localparam logic [1:0] OP_ENQ       = 2'd0;
  localparam logic [1:0] OP_DEQ_CLASS = 2'd1;
  localparam logic [1:0] OP_DEQ_ANY   = 2'd2;
  localparam logic [1:0] OP_NOP       = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef struct packed {
    tag_t tag;
    seq_t seq;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic [1:0]                opcode;
    logic                      item_class;
    logic [FIELD_TAG_BITS-1:0] payload_tag;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      out_valid_item;
    logic                      out_class;
    logic [FIELD_TAG_BITS-1:0] out_tag;
  } out_beat_t;

  typedef struct packed {
    logic   en;
    ptr_t   addr;
    entry_t data;
  } ram_wr_t;

endpackage

### sv/fcq_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
module fcq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/fcq_ctrl.sv
// Queue pointers, arrival counter, age arbitration and result register.
module fcq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fcq_pkg::in_beat_t   req,
  output logic                done,
  output fcq_pkg::out_beat_t  rsp,
  output fcq_pkg::ptr_t       rd_addr0,
  output fcq_pkg::ptr_t       rd_addr1,
  input  fcq_pkg::entry_t     rd_data0,
  input  fcq_pkg::entry_t     rd_data1,
  output fcq_pkg::ram_wr_t    wr0,
  output fcq_pkg::ram_wr_t    wr1
);

  fcq_pkg::in_beat_t cur;
  fcq_pkg::ptr_t     head0, tail0, head1, tail1;
  fcq_pkg::cnt_t     cnt0, cnt1;
  fcq_pkg::seq_t     arrival;

  logic              push_go, push_cls, pop_go, pop_cls;
  logic [1:0]        status;
  fcq_pkg::seq_t     age_diff;
  fcq_pkg::entry_t   pop_entry;
  fcq_pkg::entry_t   push_entry;
  fcq_pkg::cnt_t     push_cnt;
  fcq_pkg::cnt_t     pop_cnt;
  fcq_pkg::out_beat_t rsp_next;

  function automatic fcq_pkg::ptr_t ptr_inc(fcq_pkg::ptr_t p);
    if (p == fcq_pkg::PTR_BITS'(fcq_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + fcq_pkg::PTR_BITS'(1);
  endfunction

  assign rd_addr0 = head0;
  assign rd_addr1 = head1;

  always_comb begin
    push_go  = 1'b0;
    push_cls = cur.item_class;
    pop_go   = 1'b0;
    pop_cls  = cur.item_class;
    status   = fcq_pkg::ST_OK;
    age_diff = rd_data0.seq - rd_data1.seq;
    push_cnt = push_cls ? cnt1 : cnt0;
    pop_cnt  = '0;
    unique case (cur.opcode)
      fcq_pkg::OP_ENQ: begin
        if (push_cnt == fcq_pkg::CNT_BITS'(fcq_pkg::QUEUE_DEPTH)) begin
          status = fcq_pkg::ST_FULL;
        end else begin
          push_go = 1'b1;
        end
      end
      fcq_pkg::OP_DEQ_CLASS: begin
        pop_cnt = pop_cls ? cnt1 : cnt0;
        if (pop_cnt == '0) begin
          status = fcq_pkg::ST_EMPTY;
        end else begin
          pop_go = 1'b1;
        end
      end
      fcq_pkg::OP_DEQ_ANY: begin
        if (cnt0 == '0 && cnt1 == '0) begin
          status = fcq_pkg::ST_EMPTY;
        end else begin
          pop_go = 1'b1;
          if (cnt0 == '0) begin
            pop_cls = 1'b1;
          end else if (cnt1 == '0) begin
            pop_cls = 1'b0;
          end else begin
            // second head is older when the difference lies in the lower half, nonzero
            pop_cls = (age_diff != '0) && !age_diff[fcq_pkg::SEQ_BITS-1];
          end
        end
      end
      default: begin
      end
    endcase

    pop_entry       = pop_cls ? rd_data1 : rd_data0;
    push_entry.tag  = fcq_pkg::TAG_BITS'(cur.payload_tag);
    push_entry.seq  = arrival;

    rsp_next.status         = status;
    rsp_next.out_valid_item = pop_go;
    rsp_next.out_class      = pop_go ? pop_cls : 1'b0;
    rsp_next.out_tag        = pop_go ? fcq_pkg::FIELD_TAG_BITS'(pop_entry.tag) : '0;

    wr0.en   = busy && push_go && !push_cls;
    wr0.addr = tail0;
    wr0.data = push_entry;
    wr1.en   = busy && push_go && push_cls;
    wr1.addr = tail1;
    wr1.data = push_entry;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      head0   <= '0;
      tail0   <= '0;
      cnt0    <= '0;
      head1   <= '0;
      tail1   <= '0;
      cnt1    <= '0;
      arrival <= '0;
    end else begin
      done <= busy;
      if (busy) begin
        busy <= 1'b0;
        if (push_go) begin
          arrival <= arrival + fcq_pkg::SEQ_BITS'(1);
          if (push_cls) begin
            tail1 <= ptr_inc(tail1);
            cnt1  <= cnt1 + fcq_pkg::CNT_BITS'(1);
          end else begin
            tail0 <= ptr_inc(tail0);
            cnt0  <= cnt0 + fcq_pkg::CNT_BITS'(1);
          end
        end
        if (pop_go) begin
          if (pop_cls) begin
            head1 <= ptr_inc(head1);
            cnt1  <= cnt1 - fcq_pkg::CNT_BITS'(1);
          end else begin
            head0 <= ptr_inc(head0);
            cnt0  <= cnt0 - fcq_pkg::CNT_BITS'(1);
          end
        end
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

endmodule

### sv/two_class_fifo_oldest_first_unit.sv
// Top level of the two-class queue with oldest-first dequeue.
// A beat is taken while idle, handled while busy, and its result is registered into rsp with the done strobe.
// A new beat is not taken until the last one is done (busy is low); the head entries are read from the class RAMs
// in the accept cycle and the pointers update in the following cycle.
// Reset: synchronous rst clears pointers, counts, arrival counter and busy; RAM contents
// are left as they are. The receiver cannot stall: done flags each result for one cycle.
module two_class_fifo_oldest_first_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fcq_pkg::in_beat_t  req,
  output logic               done,
  output fcq_pkg::out_beat_t rsp
);

  fcq_pkg::ptr_t    rd_addr0, rd_addr1;
  fcq_pkg::entry_t  rd_data0, rd_data1;
  fcq_pkg::ram_wr_t wr0, wr1;

  fcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .wr0      (wr0),
    .wr1      (wr1)
  );

  fcq_ram #(
    .DEPTH (fcq_pkg::QUEUE_DEPTH),
    .WIDTH (fcq_pkg::ENTRY_BITS)
  ) u_ram0 (
    .clk   (clk),
    .we    (wr0.en),
    .waddr (wr0.addr),
    .wdata (wr0.data),
    .raddr (rd_addr0),
    .rdata (rd_data0)
  );

  fcq_ram #(
    .DEPTH (fcq_pkg::QUEUE_DEPTH),
    .WIDTH (fcq_pkg::ENTRY_BITS)
  ) u_ram1 (
    .clk   (clk),
    .we    (wr1.en),
    .waddr (wr1.addr),
    .wdata (wr1.data),
    .raddr (rd_addr1),
    .rdata (rd_data1)
  );

endmodule
